// ===== hdl/lsu_pkg.sv =====
// Shared types, constants and helpers of the load/store unit.
// No dependencies; imported by every module under hdl.
package lsu_pkg;

	// Must be a power of two; the word index is taken from the physical address bits.
	localparam int MEM_WORDS = 4096;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int CFG_IDX_W = 3;

	localparam logic [31:0] KSEG0_BASE = 32'h8000_0000;
	localparam logic [31:0] KSEG1_BASE = 32'hA000_0000;
	localparam logic [31:0] KSEG2_BASE = 32'hC000_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_RAM_RD_BASE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_RD_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_WR_BASE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_WR_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_RD_BASE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_RD_LIMIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_WR_BASE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_WR_LIMIT = 3'd7;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_MISALIGNED = 3'd1,
		ST_RANGE      = 3'd2,
		ST_UNMAPPED   = 3'd3,
		ST_DEVICE     = 3'd4
	} lsu_status_t;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2,
		SZ_RSVD = 2'd3
	} lsu_size_t;

	typedef struct packed {
		logic [31:0] ram_rd_base;
		logic [31:0] ram_rd_limit;
		logic [31:0] ram_wr_base;
		logic [31:0] ram_wr_limit;
		logic [31:0] dev_rd_base;
		logic [31:0] dev_rd_limit;
		logic [31:0] dev_wr_base;
		logic [31:0] dev_wr_limit;
	} lsu_cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic addr;
		logic xlat;
		logic win;
		logic mem;
	} lsu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fault;
	} lsu_stat_t;

	function automatic logic [31:0] lsu_translate(input logic [31:0] v);
		logic [31:0] r;
		if (v < KSEG0_BASE) begin
			r = v + KSEG0_BASE;
		end else if (v < KSEG1_BASE) begin
			r = v - KSEG0_BASE;
		end else if (v < KSEG2_BASE) begin
			r = v - KSEG1_BASE;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== hdl/lsu_cfg.sv =====
// Window configuration registers of the load/store unit.
// Depends on lsu_pkg.
module lsu_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output lsu_pkg::lsu_cfg_t              cfg
);
	import lsu_pkg::*;

	lsu_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ram_rd_base  <= 32'd0;
			cfg_q.ram_rd_limit <= 32'd16383;
			cfg_q.ram_wr_base  <= 32'd0;
			cfg_q.ram_wr_limit <= 32'd16383;
			cfg_q.dev_rd_base  <= 32'hFFFF_FFFF;
			cfg_q.dev_rd_limit <= 32'd0;
			cfg_q.dev_wr_base  <= 32'hFFFF_FFFF;
			cfg_q.dev_wr_limit <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RAM_RD_BASE:  cfg_q.ram_rd_base  <= cfg_data;
				CFG_RAM_RD_LIMIT: cfg_q.ram_rd_limit <= cfg_data;
				CFG_RAM_WR_BASE:  cfg_q.ram_wr_base  <= cfg_data;
				CFG_RAM_WR_LIMIT: cfg_q.ram_wr_limit <= cfg_data;
				CFG_DEV_RD_BASE:  cfg_q.dev_rd_base  <= cfg_data;
				CFG_DEV_RD_LIMIT: cfg_q.dev_rd_limit <= cfg_data;
				CFG_DEV_WR_BASE:  cfg_q.dev_wr_base  <= cfg_data;
				CFG_DEV_WR_LIMIT: cfg_q.dev_wr_limit <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/lsu_dp.sv =====
// Datapath: address add, range and alignment check, segment translation,
// window decode, word memory with byte lanes, load extraction. Depends on lsu_pkg.
module lsu_dp (
	input  logic                  clk,
	input  lsu_pkg::lsu_cmd_t     cmd,
	output lsu_pkg::lsu_stat_t    stat,
	input  lsu_pkg::lsu_cfg_t     cfg,
	input  logic                  action,
	input  logic [31:0]           base_address,
	input  logic signed [15:0]    address_offset,
	input  logic [1:0]            access_size,
	input  logic                  sign_extend,
	input  logic [31:0]           store_data,
	output logic [2:0]            status,
	output logic [31:0]           read_data,
	output logic [31:0]           phys_address,
	output logic                  device_is_write,
	output logic [31:0]           device_data
);
	import lsu_pkg::*;

	logic                act_q;
	logic [31:0]         base_q;
	logic signed [15:0]  off_q;
	lsu_size_t           size_q;
	logic                sx_q;
	logic [31:0]         sdata_q;

	logic [31:0]         sum_q;
	logic                oor_q;
	logic                mis_q;
	logic [31:0]         phys_q;
	logic                ram_hit_q;
	logic                dev_hit_q;
	logic [31:0]         rword_q;

	logic [3:0][7:0]     mem_q [MEM_WORDS];

	logic [32:0]         sum_c;
	logic                oor_c;
	logic                mis_c;
	logic [1:0]          lmask;
	logic [31:0]         last;
	logic [31:0]         ram_lo, ram_hi, dev_lo, dev_hi;
	logic                ram_hit_c, dev_hit_c;
	logic [MEM_AW-1:0]   idx;
	logic [3:0]          be;
	logic [3:0][7:0]     wdata;
	logic [7:0]          ld_byte;
	logic [15:0]         ld_half;
	logic [31:0]         ld_data;
	lsu_status_t         st;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action;
			base_q  <= base_address;
			off_q   <= address_offset;
			size_q  <= lsu_size_t'(access_size);
			sx_q    <= sign_extend;
			sdata_q <= store_data;
		end
	end

	// carry out flags overflow for positive offsets, its absence underflow for negative ones
	assign sum_c = {1'b0, base_q} + {1'b0, {16{off_q[15]}}, off_q};
	assign oor_c = sum_c[32] ^ off_q[15];
	assign mis_c = (size_q == SZ_RSVD) ||
		(size_q == SZ_HALF && sum_c[0]) ||
		(size_q == SZ_WORD && sum_c[1:0] != 2'b00);

	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			sum_q <= sum_c[31:0];
			oor_q <= oor_c;
			mis_q <= mis_c;
		end
		if (cmd.xlat) begin
			phys_q <= lsu_translate(sum_q);
		end
	end

	assign stat.fault = oor_q || mis_q;

	// aligned access: last byte address never carries out of the low bits
	always_comb begin
		case (size_q)
			SZ_BYTE: lmask = 2'b00;
			SZ_HALF: lmask = 2'b01;
			default: lmask = 2'b11;
		endcase
	end
	assign last   = phys_q | {30'd0, lmask};
	assign ram_lo = act_q ? cfg.ram_wr_base  : cfg.ram_rd_base;
	assign ram_hi = act_q ? cfg.ram_wr_limit : cfg.ram_rd_limit;
	assign dev_lo = act_q ? cfg.dev_wr_base  : cfg.dev_rd_base;
	assign dev_hi = act_q ? cfg.dev_wr_limit : cfg.dev_rd_limit;
	assign ram_hit_c = (ram_hi >= ram_lo) && (phys_q >= ram_lo) && (last <= ram_hi);
	assign dev_hit_c = (dev_hi >= dev_lo) && (phys_q >= dev_lo) && (last <= dev_hi);

	always_ff @(posedge clk) begin
		if (cmd.win) begin
			ram_hit_q <= ram_hit_c;
			dev_hit_q <= dev_hit_c;
		end
	end

	// big-endian lanes: lane 3 holds the byte at offset 0
	assign idx = phys_q[MEM_AW+1:2];
	always_comb begin
		case (size_q)
			SZ_BYTE: begin
				be    = 4'b1000 >> phys_q[1:0];
				wdata = {4{sdata_q[7:0]}};
			end
			SZ_HALF: begin
				be    = phys_q[1] ? 4'b0011 : 4'b1100;
				wdata = {2{sdata_q[15:0]}};
			end
			default: begin
				be    = 4'b1111;
				wdata = sdata_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem) begin
			if (ram_hit_q && act_q) begin
				for (int i = 0; i < 4; i++) begin
					if (be[i]) begin
						mem_q[idx][i] <= wdata[i];
					end
				end
			end
			rword_q <= mem_q[idx];
		end
	end

	always_comb begin
		case (phys_q[1:0])
			2'd0:    ld_byte = rword_q[31:24];
			2'd1:    ld_byte = rword_q[23:16];
			2'd2:    ld_byte = rword_q[15:8];
			default: ld_byte = rword_q[7:0];
		endcase
		ld_half = phys_q[1] ? rword_q[15:0] : rword_q[31:16];
		case (size_q)
			SZ_BYTE: ld_data = {{24{sx_q & ld_byte[7]}}, ld_byte};
			SZ_HALF: ld_data = {{16{sx_q & ld_half[15]}}, ld_half};
			default: ld_data = rword_q;
		endcase
	end

	always_comb begin
		if (oor_q) begin
			st = ST_RANGE;
		end else if (mis_q) begin
			st = ST_MISALIGNED;
		end else if (ram_hit_q) begin
			st = ST_OK;
		end else if (dev_hit_q) begin
			st = ST_DEVICE;
		end else begin
			st = ST_UNMAPPED;
		end
	end

	assign status          = st;
	assign read_data       = (st == ST_OK && !act_q) ? ld_data : 32'd0;
	assign phys_address    = (st == ST_OK || st == ST_UNMAPPED || st == ST_DEVICE) ?
		phys_q : 32'd0;
	assign device_is_write = (st == ST_DEVICE) && act_q;
	assign device_data     = (st == ST_DEVICE && act_q) ? sdata_q : 32'd0;

endmodule

// ===== hdl/lsu_ctrl.sv =====
// Sequencer of the load/store unit: steps one item through the datapath.
// Depends on lsu_pkg.
module lsu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output lsu_pkg::lsu_cmd_t     cmd,
	input  lsu_pkg::lsu_stat_t    stat
);
	import lsu_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ADDR = 6'b000010,
		S_XLAT = 6'b000100,
		S_WIN  = 6'b001000,
		S_MEM  = 6'b010000,
		S_RESP = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR: state_d = S_XLAT;
			S_XLAT: state_d = stat.fault ? S_RESP : S_WIN;
			S_WIN:  state_d = S_MEM;
			S_MEM:  state_d = S_RESP;
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_RESP);
	assign cmd.load = (state_q == S_IDLE) && start;
	assign cmd.addr = (state_q == S_ADDR);
	assign cmd.xlat = (state_q == S_XLAT);
	assign cmd.win  = (state_q == S_WIN);
	assign cmd.mem  = (state_q == S_MEM);

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state register not one-hot");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_ADDR))
		else $error("accepted item did not enter address stage");
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XLAT && stat.fault) |=> done)
		else $error("faulting item not reported next cycle");
	a_mem_done: assert property (@(posedge clk) disable iff (!arst_n) cmd.mem |=> done)
		else $error("memory access not followed by result");
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== hdl/mips_load_store_unit.sv =====
// Top level of the load/store unit: config registers, sequencer and datapath.
// Depends on lsu_pkg, lsu_cfg, lsu_ctrl, lsu_dp.
//
// One item is accepted when start is high and busy is low. The result appears
// with done high for exactly one cycle and must be taken then; there is no
// backpressure. busy stays high until the result is given, so no new item is
// accepted before the last one is through. The sequencer steps each item
// through address add, segment translation, window decode, one access of the
// single-port word memory and the result; a range or alignment fault skips
// window decode and memory. Config writes are always ready and must be issued
// while busy is low. Memory contents are undefined until written.
module mips_load_store_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           action,
	input  logic [31:0]                    base_address,
	input  logic signed [15:0]             address_offset,
	input  logic [1:0]                     access_size,
	input  logic                           sign_extend,
	input  logic [31:0]                    store_data,
	output logic                           done,
	output logic [2:0]                     status,
	output logic [31:0]                    read_data,
	output logic [31:0]                    phys_address,
	output logic                           device_is_write,
	output logic [31:0]                    device_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lsu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import lsu_pkg::*;

	lsu_cfg_t  cfg;
	lsu_cmd_t  cmd;
	lsu_stat_t stat;

	lsu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	lsu_dp u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.stat            (stat),
		.cfg             (cfg),
		.action          (action),
		.base_address    (base_address),
		.address_offset  (address_offset),
		.access_size     (access_size),
		.sign_extend     (sign_extend),
		.store_data      (store_data),
		.status          (status),
		.read_data       (read_data),
		.phys_address    (phys_address),
		.device_is_write (device_is_write),
		.device_data     (device_data)
	);

endmodule
